@@ design/bdqd_pkg.sv @@
// Shared types, constants and phase tables for the button debounce and
// quadrature decode block. Depends on nothing; imported by all but the checker.
package bdqd_pkg;

  localparam int unsigned NumButtons   = 9;
  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned DebounceWidth = 16;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned InDataWidth  = 48;
  localparam int unsigned OutDataWidth = 24;

  localparam logic [DebounceWidth-1:0] DebounceReset = 16'd50;

  // Direction codes, two's complement: forward is +1, backward is -1.
  localparam logic [1:0] DirNone = 2'b00;
  localparam logic [1:0] DirFwd  = 2'b01;
  localparam logic [1:0] DirBack = 2'b11;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgButtonMask = 3'd0,
    CfgDebounce   = 3'd1,
    CfgJogEn      = 3'd2,
    CfgPitchEn    = 3'd3,
    CfgTouchEn    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [NumButtons-1:0]    button_mask;
    logic [DebounceWidth-1:0] debounce_ms;
    logic                     jog_en;
    logic                     pitch_en;
    logic                     touch_en;
  } cfg_t;

  // Phase that follows a forward step along 0 -> 1 -> 3 -> 2 -> 0.
  function automatic logic [1:0] fwd_next(input logic [1:0] phase);
    logic [1:0] nxt;
    case (phase)
      2'd0:    nxt = 2'd1;
      2'd1:    nxt = 2'd3;
      2'd2:    nxt = 2'd0;
      2'd3:    nxt = 2'd2;
      default: nxt = 2'd0;
    endcase
    return nxt;
  endfunction

  // Phase that follows a backward step, the reverse sequence.
  function automatic logic [1:0] back_next(input logic [1:0] phase);
    logic [1:0] nxt;
    case (phase)
      2'd0:    nxt = 2'd2;
      2'd1:    nxt = 2'd0;
      2'd2:    nxt = 2'd3;
      2'd3:    nxt = 2'd1;
      default: nxt = 2'd0;
    endcase
    return nxt;
  endfunction

endpackage

@@ design/bdqd_debounce.sv @@
// Per-button debounce: holds stable state, last raw sample and change time.
// Depends on bdqd_pkg.
module bdqd_debounce (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [bdqd_pkg::TimeWidth-1:0]      now_ms_i,
  input  logic [bdqd_pkg::NumButtons-1:0]     levels_i,
  input  logic [bdqd_pkg::NumButtons-1:0]     mask_i,
  input  logic [bdqd_pkg::DebounceWidth-1:0]  debounce_ms_i,
  output logic [bdqd_pkg::NumButtons-1:0]     stable_o,
  output logic [bdqd_pkg::NumButtons-1:0]     changed_o
);
  import bdqd_pkg::*;

  logic [NumButtons-1:0] stable_q, stable_d;
  logic [NumButtons-1:0] prev_q, prev_d;
  logic [NumButtons-1:0] changed;
  logic [NumButtons-1:0] pressed;
  logic [TimeWidth-1:0]  change_time_q [NumButtons];
  logic [TimeWidth-1:0]  change_time_d [NumButtons];
  logic [TimeWidth-1:0]  elapsed       [NumButtons];

  assign pressed = ~levels_i;

  always_comb begin
    for (int i = 0; i < NumButtons; i++) begin
      stable_d[i]      = stable_q[i];
      prev_d[i]        = pressed[i];
      changed[i]       = 1'b0;
      change_time_d[i] = change_time_q[i];
      if (pressed[i] != prev_q[i]) begin
        change_time_d[i] = now_ms_i;
      end
      // Wrapping subtraction gives the elapsed time across a counter rollover.
      elapsed[i] = now_ms_i - change_time_d[i];
      if (elapsed[i] > {{(TimeWidth-DebounceWidth){1'b0}}, debounce_ms_i} &&
          pressed[i] != stable_q[i]) begin
        stable_d[i] = pressed[i];
        changed[i]  = 1'b1;
      end
      // A disabled button reads as released and keeps its change time.
      if (!mask_i[i]) begin
        stable_d[i]      = 1'b0;
        prev_d[i]        = 1'b0;
        changed[i]       = 1'b0;
        change_time_d[i] = change_time_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '0;
      prev_q   <= '0;
      for (int i = 0; i < NumButtons; i++) begin
        change_time_q[i] <= '0;
      end
    end else if (step_i) begin
      stable_q <= stable_d;
      prev_q   <= prev_d;
      for (int i = 0; i < NumButtons; i++) begin
        change_time_q[i] <= change_time_d[i];
      end
    end
  end

  assign stable_o  = stable_d;
  assign changed_o = changed;

endmodule

@@ design/bdqd_quad.sv @@
// One quadrature decoder: stored phase and direction of the last legal step.
// Depends on bdqd_pkg for the direction codes and phase tables.
module bdqd_quad (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              enable_i,
  input  logic              phase_a_i,
  input  logic              phase_b_i,
  input  logic              take_i,
  output logic signed [1:0] direction_o
);
  import bdqd_pkg::*;

  logic [1:0] phase;
  logic [1:0] phase_q, phase_d;
  logic [1:0] dir_q, dir_now;

  assign phase = enable_i ? {phase_a_i, phase_b_i} : 2'b00;

  always_comb begin
    phase_d = phase_q;
    dir_now = dir_q;
    if (phase != phase_q) begin
      // An illegal jump (both bits changed) only moves the stored phase.
      if (fwd_next(phase_q) == phase) begin
        dir_now = DirFwd;
      end else if (back_next(phase_q) == phase) begin
        dir_now = DirBack;
      end
      phase_d = phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'b00;
      dir_q   <= DirNone;
    end else if (step_i) begin
      phase_q <= phase_d;
      dir_q   <= take_i ? DirNone : dir_now;
    end
  end

  assign direction_o = $signed(dir_now);

endmodule

@@ design/button_debounce_quadrature_decode_top.sv @@
// Top level of the button debounce and quadrature decode block: input register,
// configuration registers, result register. Depends on bdqd_pkg, bdqd_debounce, bdqd_quad.
//
//   Channel   Direction  Width  Contents
//   s_axis    in         48     one pin sample with its millisecond timestamp
//   m_axis    out        24     debounced buttons, change mask, directions, touch
//   cfg       in         16     register write, index 0..4, no read-back
//
// The accepted request is held in the input register, which feeds the debounce
// compares; these load the result register whenever it can take a sample. One
// sample is accepted every cycle unless the result stalls; the 32-bit elapsed-time
// compare per button sets the cycle time. A stalled result holds the input register, and
// s_axis_tready falls only when both registers are full and m_axis_tready is low.
// Reset clears all button, phase and direction state and the valid flags of both registers.
module button_debounce_quadrature_decode_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bdqd_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [bdqd_pkg::CfgDataWidth-1:0]   cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // now_ms[31:0], button_levels[40:32], jog_phase_a[41], jog_phase_b[42],
  // pitch_phase_a[43], pitch_phase_b[44], touch_level[45], take_jog[46],
  // take_pitch[47]
  input  logic [bdqd_pkg::InDataWidth-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // stable_buttons[8:0], changed_buttons[17:9], jog_direction[19:18],
  // pitch_direction[21:20], touch_pressed[22], zero[23]
  output logic [bdqd_pkg::OutDataWidth-1:0]   m_axis_tdata
);
  import bdqd_pkg::*;

  cfg_t cfg_q;

  logic                  in_valid_q;
  logic [TimeWidth-1:0]  now_ms_q;
  logic [NumButtons-1:0] levels_q;
  logic                  jog_a_q, jog_b_q, pitch_a_q, pitch_b_q;
  logic                  touch_level_q, take_jog_q, take_pitch_q;

  logic                  advance;
  logic                  in_accept;
  logic [NumButtons-1:0] stable;
  logic [NumButtons-1:0] changed;
  logic signed [1:0]     jog_dir;
  logic signed [1:0]     pitch_dir;
  logic                  touch_pressed;

  logic                    out_valid_q;
  logic [OutDataWidth-1:0] out_data_q;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.button_mask <= '1;
      cfg_q.debounce_ms <= DebounceReset;
      cfg_q.jog_en      <= 1'b1;
      cfg_q.pitch_en    <= 1'b1;
      cfg_q.touch_en    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgButtonMask: cfg_q.button_mask <= cfg_wdata_i[NumButtons-1:0];
        CfgDebounce:   cfg_q.debounce_ms <= cfg_wdata_i[DebounceWidth-1:0];
        CfgJogEn:      cfg_q.jog_en      <= cfg_wdata_i[0];
        CfgPitchEn:    cfg_q.pitch_en    <= cfg_wdata_i[0];
        CfgTouchEn:    cfg_q.touch_en    <= cfg_wdata_i[0];
        default:       ;
      endcase
    end
  end

  // The input register moves on whenever the result register can take a sample.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_ms_q      <= s_axis_tdata[31:0];
      levels_q      <= s_axis_tdata[40:32];
      jog_a_q       <= s_axis_tdata[41];
      jog_b_q       <= s_axis_tdata[42];
      pitch_a_q     <= s_axis_tdata[43];
      pitch_b_q     <= s_axis_tdata[44];
      touch_level_q <= s_axis_tdata[45];
      take_jog_q    <= s_axis_tdata[46];
      take_pitch_q  <= s_axis_tdata[47];
    end
  end

  bdqd_debounce u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .now_ms_i      (now_ms_q),
    .levels_i      (levels_q),
    .mask_i        (cfg_q.button_mask),
    .debounce_ms_i (cfg_q.debounce_ms),
    .stable_o      (stable),
    .changed_o     (changed)
  );

  bdqd_quad u_jog (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .enable_i    (cfg_q.jog_en),
    .phase_a_i   (jog_a_q),
    .phase_b_i   (jog_b_q),
    .take_i      (take_jog_q),
    .direction_o (jog_dir)
  );

  bdqd_quad u_pitch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .enable_i    (cfg_q.pitch_en),
    .phase_a_i   (pitch_a_q),
    .phase_b_i   (pitch_b_q),
    .take_i      (take_pitch_q),
    .direction_o (pitch_dir)
  );

  assign touch_pressed = cfg_q.touch_en & ~touch_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {1'b0, touch_pressed, pitch_dir, jog_dir, changed, stable};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ design/bdqd_checker.sv @@
// Port-level checks for the button debounce and quadrature decode top level,
// bound to it below. Depends only on the top level's ports.
module bdqd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A held result must not change under backpressure.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // With the result register empty the block always takes a new request.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // Direction fields only ever carry none, forward or backward.
  a_dir_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[19:18] != 2'b10 && m_axis_tdata[21:20] != 2'b10)
    else $error("illegal direction code");

  // The pad bit above the touch flag stays zero in every result.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[23])
    else $error("pad bit set");

endmodule

bind button_debounce_quadrature_decode_top bdqd_checker u_bdqd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
